// ===== rtl/vavt_pkg.sv =====
// package for the view area visibility test
// holds fixed-point widths, pipeline depths, register codes and the cordic angle table
// no dependencies
package vavt_pkg;

    localparam int LANES          = 4;
    localparam int CORDIC_STEPS   = 20;
    // lane stages: prep, one per cordic step, final window check
    localparam int LANE_STAGES    = CORDIC_STEPS + 2;
    // pipeline: input register, lane stages, output register
    localparam int NUM_STAGES     = LANE_STAGES + 2;
    localparam int CW             = 52;
    localparam int ZW             = 25;
    localparam int LARGE_BOX_SIDE = 256000;
    localparam int DEG180         = 5898240;
    localparam int DEG360         = 11796480;
    localparam int FULL_TURN      = 46080;
    localparam int ONE_Q14        = 16384;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_VIEW_DIR  = 3'd3,
        REG_ANGLE_MIN = 3'd4,
        REG_ANGLE_MAX = 3'd5,
        REG_HMODE     = 3'd6
    } reg_idx_t;

    // per-item decision flags carried alongside the lanes
    typedef struct packed {
        logic cmd;
        logic ign;
        logic in_x;
        logic in_y;
        logic in_z;
        logic ov_x;
        logic ov_y;
        logic ov_z;
        logic big;
    } flags_t;

    // atan(2^-i) in 1/32768 degree
    function automatic logic signed [ZW-1:0] cordic_atan(input int i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                0:  v = 25'sd1474560;
                1:  v = 25'sd870484;
                2:  v = 25'sd459940;
                3:  v = 25'sd233473;
                4:  v = 25'sd117189;
                5:  v = 25'sd58652;
                6:  v = 25'sd29333;
                7:  v = 25'sd14667;
                8:  v = 25'sd7334;
                9:  v = 25'sd3667;
                10: v = 25'sd1833;
                11: v = 25'sd917;
                12: v = 25'sd458;
                13: v = 25'sd229;
                14: v = 25'sd115;
                15: v = 25'sd57;
                16: v = 25'sd29;
                17: v = 25'sd14;
                18: v = 25'sd7;
                19: v = 25'sd4;
                default: v = 25'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/vavt_lane.sv =====
// one sector-test lane: radius compare and pipelined cordic azimuth with window check
// depends on vavt_pkg
module vavt_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [vavt_pkg::LANE_STAGES-1:0]   en,
    input  logic signed [23:0]                 px,
    input  logic signed [23:0]                 pz,
    input  logic signed [23:0]                 ox,
    input  logic signed [23:0]                 oz,
    input  logic [22:0]                        r,
    input  logic [15:0]                        amin,
    input  logic [15:0]                        amax,
    output logic                               hit
);
    import vavt_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 zero_reg [CORDIC_STEPS+1];
    logic                 dist_reg [CORDIC_STEPS+1];
    logic [49:0]          sqx_reg, sqz_reg;
    logic [45:0]          rr_reg;
    logic                 hit_reg;

    // prep: offsets, squares, half-plane fold
    logic signed [24:0]   dx, dz;
    logic signed [49:0]   sqx, sqz;
    logic signed [CW-1:0] xp, yp;
    logic                 neg;

    always_comb
    begin
        dx  = {px[23], px} - {ox[23], ox};
        dz  = {pz[23], pz} - {oz[23], oz};
        sqx = dx * dx;
        sqz = dz * dz;
        xp  = {{(CW-25){dx[24]}}, dx} <<< 24;
        yp  = {{(CW-25){dz[24]}}, dz} <<< 24;
        neg = dx[24];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= neg ? -xp : xp;
            y_reg[0]    <= neg ? -yp : yp;
            z_reg[0]    <= neg ? ZW'(DEG180) : '0;
            zero_reg[0] <= (dx == 25'sd0) && (dz == 25'sd0);
            dist_reg[0] <= 1'b0;
            sqx_reg     <= 50'(sqx);
            sqz_reg     <= 50'(sqz);
            rr_reg      <= r * r;
        end
    end

    // squared distance in the xz plane
    logic [50:0] d2;

    assign d2 = {1'b0, sqx_reg} + {1'b0, sqz_reg};

    // cordic vectoring, one step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] xs, ys;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
        end

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + cordic_atan(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - cordic_atan(i);
                end
                zero_reg[i+1] <= zero_reg[i];
                if (i == 0)
                    dist_reg[i+1] <= d2 <= {5'd0, rr_reg};
                else
                    dist_reg[i+1] <= dist_reg[i];
            end
        end
    end

    // final: wrap, round to 1/128 degree, window check
    logic signed [ZW-1:0] zw;
    logic [24:0]          zr;
    logic [16:0]          a17;
    logic [15:0]          a;
    logic                 win;

    always_comb
    begin
        zw  = z_reg[CORDIC_STEPS];
        if (zw < 0)
            zw = zw + ZW'(DEG360);
        zr  = 25'(zw) + 25'd128;
        a17 = zr[24:8];
        if (zero_reg[CORDIC_STEPS] || (a17 >= 17'(FULL_TURN)))
            a = '0;
        else
            a = a17[15:0];
        if (amax < amin)
            win = !((amax < a) && (a < amin));
        else
            win = !((a < amin) || (amax < a));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (en[LANE_STAGES-1])
            hit_reg <= dist_reg[CORDIC_STEPS] && win;
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/view_area_visibility_test.sv =====
// top level of the view area visibility test: config registers, box bounds,
// four corner lanes and the merging output stage; depends on vavt_pkg and vavt_lane
// out_valid rises once the accepted input beat has passed the input register, lane stages and output register;
// throughput one beat per cycle while the output is not held by out_stall
// the four cordic lanes are fully pipelined, one stage per step; per-stage valid bits
// let bubbles collapse, so input is stalled only when every stage holds an item
// reset: pipeline empty, origin and direction zero, angle window 0..46079, horizontal mode on
module view_area_visibility_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic signed [23:0] x_or_min_x,
    input  logic signed [23:0] y_or_min_y,
    input  logic signed [23:0] z_or_min_z,
    input  logic signed [23:0] max_x,
    input  logic signed [23:0] max_y,
    input  logic signed [23:0] max_z,
    input  logic [22:0]        radius,
    input  logic               ignore_height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               visible
);
    import vavt_pkg::*;

    // configuration registers
    logic signed [23:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [47:0]        view_dir_reg;
    logic [15:0]        angle_min_reg, angle_max_reg;
    logic               hmode_reg;
    reg_idx_t           widx;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            view_dir_reg  <= '0;
            angle_min_reg <= '0;
            angle_max_reg <= 16'(FULL_TURN - 1);
            hmode_reg     <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                REG_ORIGIN_X:  origin_x_reg  <= pwdata[23:0];
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata[23:0];
                REG_ORIGIN_Z:  origin_z_reg  <= pwdata[23:0];
                REG_VIEW_DIR:  view_dir_reg  <= pwdata[47:0];
                REG_ANGLE_MIN: angle_min_reg <= pwdata[15:0];
                REG_ANGLE_MAX: angle_max_reg <= pwdata[15:0];
                REG_HMODE:     hmode_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (widx)
            REG_ORIGIN_X:  prdata = {{40{origin_x_reg[23]}}, origin_x_reg};
            REG_ORIGIN_Y:  prdata = {{40{origin_y_reg[23]}}, origin_y_reg};
            REG_ORIGIN_Z:  prdata = {{40{origin_z_reg[23]}}, origin_z_reg};
            REG_VIEW_DIR:  prdata = {16'd0, view_dir_reg};
            REG_ANGLE_MIN: prdata = {48'd0, angle_min_reg};
            REG_ANGLE_MAX: prdata = {48'd0, angle_max_reg};
            REG_HMODE:     prdata = {63'd0, hmode_reg};
            default:       prdata = '0;
        endcase
    end

    // per-stage valid and advance chain
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || !out_stall;
        for (int k = NUM_STAGES-2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NUM_STAGES; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NUM_STAGES-1];

    // stage 0: input beat register
    logic signed [23:0] lo0_reg [3];
    logic signed [23:0] hi0_reg [3];
    logic [22:0]        r0_reg;
    logic               cmd0_reg, ign0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo0_reg[0] <= x_or_min_x;
            lo0_reg[1] <= y_or_min_y;
            lo0_reg[2] <= z_or_min_z;
            hi0_reg[0] <= max_x;
            hi0_reg[1] <= max_y;
            hi0_reg[2] <= max_z;
            r0_reg     <= radius;
            cmd0_reg   <= cmd;
            ign0_reg   <= ignore_height;
        end
    end

    // stage 1: bound products and largest side
    logic signed [15:0] dir_c [3];
    logic signed [40:0] plo [3];
    logic signed [40:0] phi [3];
    logic signed [24:0] side [3];
    logic signed [24:0] smax;

    assign dir_c[0] = view_dir_reg[15:0];
    assign dir_c[1] = view_dir_reg[31:16];
    assign dir_c[2] = view_dir_reg[47:32];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            plo[k]  = ($signed({dir_c[k][15], dir_c[k]}) - 17'(ONE_Q14))
                      * $signed({1'b0, r0_reg});
            phi[k]  = ($signed({dir_c[k][15], dir_c[k]}) + 17'(ONE_Q14))
                      * $signed({1'b0, r0_reg});
            side[k] = {hi0_reg[k][23], hi0_reg[k]} - {lo0_reg[k][23], lo0_reg[k]};
        end
        smax = side[0];
        if (smax < side[1])
            smax = side[1];
        if (smax < side[2])
            smax = side[2];
    end

    logic signed [40:0] plo1_reg [3];
    logic signed [40:0] phi1_reg [3];
    logic signed [23:0] lo1_reg [3];
    logic signed [23:0] hi1_reg [3];
    logic               cmd1_reg, ign1_reg, big1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            plo1_reg <= plo;
            phi1_reg <= phi;
            lo1_reg  <= lo0_reg;
            hi1_reg  <= hi0_reg;
            cmd1_reg <= cmd0_reg;
            ign1_reg <= ign0_reg;
            big1_reg <= smax > 25'(LARGE_BOX_SIDE);
        end
    end

    // stage 2: view box bounds and compares
    logic signed [23:0] org [3];
    logic signed [26:0] bmin [3];
    logic signed [26:0] bmax [3];
    logic signed [26:0] lo27 [3];
    logic signed [26:0] hi27 [3];
    logic signed [40:0] slo [3];
    logic signed [40:0] shi [3];
    logic [2:0]         in_box, overlap;
    flags_t             fl_next;

    assign org[0] = origin_x_reg;
    assign org[1] = origin_y_reg;
    assign org[2] = origin_z_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            slo[k]     = plo1_reg[k] >>> 15;
            shi[k]     = phi1_reg[k] >>> 15;
            bmin[k]    = {{3{org[k][23]}}, org[k]} + slo[k][26:0];
            bmax[k]    = {{3{org[k][23]}}, org[k]} + shi[k][26:0];
            lo27[k]    = {{3{lo1_reg[k][23]}}, lo1_reg[k]};
            hi27[k]    = {{3{hi1_reg[k][23]}}, hi1_reg[k]};
            in_box[k]  = !((lo27[k] < bmin[k]) || (bmax[k] < lo27[k]));
            overlap[k] = !((hi27[k] < bmin[k]) || (bmax[k] < lo27[k]));
        end
        fl_next.cmd  = cmd1_reg;
        fl_next.ign  = ign1_reg;
        fl_next.in_x = in_box[0];
        fl_next.in_y = in_box[1];
        fl_next.in_z = in_box[2];
        fl_next.ov_x = overlap[0];
        fl_next.ov_y = overlap[1];
        fl_next.ov_z = overlap[2];
        fl_next.big  = big1_reg;
    end

    // flags travel alongside the lanes
    flags_t fl_reg [2:LANE_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[2])
            fl_reg[2] <= fl_next;
        for (int k = 3; k <= LANE_STAGES; k++)
            if (en[k])
                fl_reg[k] <= fl_reg[k-1];
    end

    // corner lanes: (lo x, lo z), (lo x, hi z), (hi x, lo z), (hi x, hi z)
    logic [LANES-1:0] hit;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        vavt_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en[LANE_STAGES:1]),
            .px    ((l / 2 == 1) ? hi0_reg[0] : lo0_reg[0]),
            .pz    ((l % 2 == 1) ? hi0_reg[2] : lo0_reg[2]),
            .ox    (origin_x_reg),
            .oz    (origin_z_reg),
            .r     (r0_reg),
            .amin  (angle_min_reg),
            .amax  (angle_max_reg),
            .hit   (hit[l])
        );
    end

    // merge stage and output register
    flags_t f;
    logic   ycheck;
    logic   vis_next;
    logic   visible_reg;

    always_comb
    begin
        f      = fl_reg[LANE_STAGES];
        ycheck = f.ign || f.in_y;
        priority if (!f.cmd)
        begin
            if (hmode_reg)
                vis_next = ycheck && f.in_x && f.in_z;
            else
                vis_next = ycheck && hit[0];
        end
        else if (hmode_reg || f.big)
            vis_next = f.ov_x && f.ov_y && f.ov_z;
        else if (!f.ov_y)
            vis_next = 1'b0;
        else
            vis_next = |hit;
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
            visible_reg <= vis_next;
    end

    assign visible = visible_reg;

    // input stalls only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&v_reg) && out_stall))
        else $error("input stalled with room in the pipeline");

    // a taken output beat with nothing behind leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !v_reg[NUM_STAGES-2]) |=> !out_valid)
        else $error("output beat repeated");

    // a taken output beat with an item behind is refilled at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && v_reg[NUM_STAGES-2]) |=> out_valid)
        else $error("item lost at the output stage");

endmodule

// ===== verif/tb_view_area_visibility_test.sv =====
// testbench for view_area_visibility_test: queue-fed driver, clocked monitor, in-bench predictor
// depends on vavt_pkg and the view_area_visibility_test rtl
`timescale 1ns / 100ps

module tb_view_area_visibility_test;
    import vavt_pkg::*;

    // one query beat
    typedef struct {
        logic        cmd;
        logic [23:0] px, py, pz, qx, qy, qz;
        logic [22:0] rad;
        logic        ign;
    } query_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [5:0] paddr;
    logic [63:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall;
    logic cmd;
    logic signed [23:0] x_or_min_x, y_or_min_y, z_or_min_z, max_x, max_y, max_z;
    logic [22:0] radius;
    logic ignore_height;
    logic out_valid, out_stall, visible;

    view_area_visibility_test u_dut (.*);

    // predictor copy of the view setup
    longint org_x, org_y, org_z;
    longint dir_v [3];
    longint win_lo, win_hi;
    bit     hmode;

    query_t pending_q [$];
    bit     vis_expected_q [$];
    bit     exp_vis;
    int     errors;
    int     gap_cnt;
    int     stall_cnt;
    bit     hold_send;

    const int atan_steps [20] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
        14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4};

    function automatic longint sx24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint sra(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint azimuth_units(longint dx, longint dz);
        longint x, y, z, xs, ys, a;
        x = dx * 16777216;
        y = dz * 16777216;
        z = 0;
        if (dx == 0 && dz == 0)
            return 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = DEG180;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = sra(x, i);
            ys = sra(y, i);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_steps[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_steps[i];
            end
        end
        while (z < 0)
            z += DEG360;
        while (z >= DEG360)
            z -= DEG360;
        a = (z + 128) >>> 8;
        if (a >= FULL_TURN)
            a = 0;
        return a;
    endfunction

    function automatic bit corner_in_sector(longint cx, longint cz, longint r);
        longint dx, dz, a;
        dx = cx - org_x;
        dz = cz - org_z;
        if (r * r < dx * dx + dz * dz)
            return 0;
        a = azimuth_units(dx, dz);
        if (win_hi < win_lo)
            return !(win_hi < a && a < win_lo);
        return !(a < win_lo || win_hi < a);
    endfunction

    function automatic bit predict_visible(query_t q);
        longint lo [3], hi [3], bmin [3], bmax [3], org [3];
        longint r, side;
        bit vis, ycheck;
        r = longint'(q.rad);
        org[0] = org_x; org[1] = org_y; org[2] = org_z;
        lo[0] = sx24(q.px); lo[1] = sx24(q.py); lo[2] = sx24(q.pz);
        hi[0] = sx24(q.qx); hi[1] = sx24(q.qy); hi[2] = sx24(q.qz);
        for (int k = 0; k < 3; k++)
        begin
            bmin[k] = org[k] + sra((dir_v[k] - ONE_Q14) * r, 15);
            bmax[k] = org[k] + sra((dir_v[k] + ONE_Q14) * r, 15);
        end
        if (!q.cmd)
        begin
            ycheck = q.ign || !(lo[1] < bmin[1] || bmax[1] < lo[1]);
            if (hmode)
                vis = ycheck && !(lo[0] < bmin[0] || bmax[0] < lo[0])
                      && !(lo[2] < bmin[2] || bmax[2] < lo[2]);
            else
                vis = ycheck && corner_in_sector(lo[0], lo[2], r);
        end
        else
        begin
            side = hi[0] - lo[0];
            if (side < hi[1] - lo[1]) side = hi[1] - lo[1];
            if (side < hi[2] - lo[2]) side = hi[2] - lo[2];
            if (hmode || side > LARGE_BOX_SIDE)
            begin
                vis = 1;
                for (int k = 0; k < 3; k++)
                    if (hi[k] < bmin[k] || bmax[k] < lo[k])
                        vis = 0;
            end
            else if (hi[1] < bmin[1] || bmax[1] < lo[1])
                vis = 0;
            else
                vis = corner_in_sector(lo[0], lo[2], r) || corner_in_sector(lo[0], hi[2], r)
                      || corner_in_sector(hi[0], lo[2], r)
                      || corner_in_sector(hi[0], hi[2], r);
        end
        return vis;
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(5, 30);
        return $urandom_range(0, 2);
    endfunction

    // driver: one beat from the pending queue, held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            gap_cnt  <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                vis_expected_q.push_back(predict_visible(pending_q.pop_front()));
            if (in_valid && pending_q.size() > 0 && pick_gap() == 0 && !hold_send)
            begin
                cmd <= pending_q[0].cmd; x_or_min_x <= pending_q[0].px;
                y_or_min_y <= pending_q[0].py; z_or_min_z <= pending_q[0].pz;
                max_x <= pending_q[0].qx; max_y <= pending_q[0].qy; max_z <= pending_q[0].qz;
                radius <= pending_q[0].rad; ignore_height <= pending_q[0].ign;
            end
            else if (in_valid)
            begin
                in_valid <= 0;
                gap_cnt  <= pick_gap();
            end
            else if (gap_cnt > 0)
                gap_cnt <= gap_cnt - 1;
            else if (pending_q.size() > 0 && !hold_send)
            begin
                in_valid <= 1;
                cmd <= pending_q[0].cmd; x_or_min_x <= pending_q[0].px;
                y_or_min_y <= pending_q[0].py; z_or_min_z <= pending_q[0].pz;
                max_x <= pending_q[0].qx; max_y <= pending_q[0].qy; max_z <= pending_q[0].qz;
                radius <= pending_q[0].rad; ignore_height <= pending_q[0].ign;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            stall_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (vis_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual visible=%0b",
                             $time, visible);
                    errors++;
                end
                else
                begin
                    exp_vis = vis_expected_q.pop_front();
                    if (exp_vis !== visible)
                    begin
                        $display("%0t: visible mismatch, expected %0b, actual %0b",
                                 $time, exp_vis, visible);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0)
                stall_cnt <= stall_cnt - 1;
            else if (out_stall)
                out_stall <= 0;
            else if ($urandom_range(0, 5) == 0)
            begin
                out_stall <= 1;
                stall_cnt <= pick_gap();
            end
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_ORIGIN_X:  org_x = sx24(val[23:0]);
            REG_ORIGIN_Y:  org_y = sx24(val[23:0]);
            REG_ORIGIN_Z:  org_z = sx24(val[23:0]);
            REG_VIEW_DIR:
            begin
                dir_v[0] = longint'(signed'(val[15:0]));
                dir_v[1] = longint'(signed'(val[31:16]));
                dir_v[2] = longint'(signed'(val[47:32]));
            end
            REG_ANGLE_MIN: win_lo = val[15:0];
            REG_ANGLE_MAX: win_hi = val[15:0];
            REG_HMODE:     hmode = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || in_valid || vis_expected_q.size() > 0)
            @(posedge clk);
        repeat (NUM_STAGES + 4) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_coord(int mode);
        logic [23:0] v;
        v = 24'($urandom);
        if (mode == 0)
            v = 24'($signed($urandom_range(0, 40000)) - 20000);
        return v;
    endfunction

    // queries near the origin, mostly well-formed boxes, some full-range noise
    function automatic query_t rand_query();
        query_t q;
        int m;
        int b;
        m = ($urandom_range(0, 9) == 0) ? 1 : 0;
        q.cmd = 1'($urandom_range(0, 1));
        q.ign = 1'($urandom_range(0, 1));
        q.rad = m ? 23'($urandom) : 23'($urandom_range(0, 30000));
        q.px = rand_coord(m ? 1 : 0);
        q.py = rand_coord(m ? 1 : 0);
        q.pz = rand_coord(m ? 1 : 0);
        if (!m && $urandom_range(0, 3) != 0)
        begin
            b = $urandom_range(0, $urandom_range(0, 1) ? 3000 : 300000);
            q.qx = q.px + 24'($urandom_range(0, b));
            q.qy = q.py + 24'($urandom_range(0, b));
            q.qz = q.pz + 24'($urandom_range(0, b));
        end
        else
        begin
            q.qx = rand_coord(m ? 1 : 0);
            q.qy = rand_coord(m ? 1 : 0);
            q.qz = rand_coord(m ? 1 : 0);
        end
        return q;
    endfunction

    function automatic query_t mk(logic c, longint ax, longint ay, longint az, longint bx,
                                  longint by, longint bz, longint r, logic ig);
        query_t q;
        q.cmd = c; q.px = 24'(ax); q.py = 24'(ay); q.pz = 24'(az);
        q.qx = 24'(bx); q.qy = 24'(by); q.qz = 24'(bz);
        q.rad = 23'(r); q.ign = ig;
        return q;
    endfunction

    task automatic random_setup(bit extreme);
        logic [15:0] d [3];
        for (int k = 0; k < 3; k++)
            d[k] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768) - 16384);
        apb_write(REG_ORIGIN_X, extreme ? 64'($urandom) : 64'($urandom_range(0, 4000) - 2000));
        apb_write(REG_ORIGIN_Y, extreme ? 64'($urandom) : 64'($urandom_range(0, 4000) - 2000));
        apb_write(REG_ORIGIN_Z, extreme ? 64'($urandom) : 64'($urandom_range(0, 4000) - 2000));
        apb_write(REG_VIEW_DIR, {16'h0, d[2], d[1], d[0]});
        apb_write(REG_ANGLE_MIN, extreme ? 64'($urandom & 16'hffff) : 64'($urandom_range(0, 46079)));
        apb_write(REG_ANGLE_MAX, extreme ? 64'($urandom & 16'hffff) : 64'($urandom_range(0, 46079)));
        apb_write(REG_HMODE, 64'($urandom_range(0, 3) == 0));
    endtask

    initial
    begin
        errors = 0; hold_send = 0;
        rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        cmd = 0; x_or_min_x = 0; y_or_min_y = 0; z_or_min_z = 0;
        max_x = 0; max_y = 0; max_z = 0; radius = 0; ignore_height = 0;
        org_x = 0; org_y = 0; org_z = 0; dir_v[0] = 0; dir_v[1] = 0; dir_v[2] = 0;
        win_lo = 0; win_hi = 46079; hmode = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // directed: reset setup, extremes of fields
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(0, 8388607, -8388608, 8388607, 0, 0, 0, 8388607, 1));
        pending_q.push_back(mk(1, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                               8388607, 0));
        pending_q.push_back(mk(1, 10, 10, 10, -10, -10, -10, 100, 1));
        pending_q.push_back(mk(0, 100, 5000, 100, 0, 0, 0, 200, 0));
        pending_q.push_back(mk(0, 100, 5000, 100, 0, 0, 0, 200, 1));
        wait_drained();

        // sector mode, wrapping window, zero vector and large box cases
        apb_write(REG_HMODE, 64'd0);
        apb_write(REG_ANGLE_MIN, 64'd40000);
        apb_write(REG_ANGLE_MAX, 64'd2000);
        apb_write(REG_VIEW_DIR, 64'h0000_4000_0000);
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1000, 0));
        pending_q.push_back(mk(0, 500, 0, 10, 0, 0, 0, 1000, 0));
        pending_q.push_back(mk(0, 500, 0, -10, 0, 0, 0, 1000, 0));
        pending_q.push_back(mk(0, -500, 0, 0, 0, 0, 0, 1000, 1));
        pending_q.push_back(mk(0, 0, 0, 500, 0, 0, 0, 1000, 1));
        pending_q.push_back(mk(0, 707, 0, 708, 0, 0, 0, 1000, 1));
        pending_q.push_back(mk(1, -100, -100, -100, 100, 100, 100, 1000, 0));
        pending_q.push_back(mk(1, 0, 0, 0, 256000, 10, 10, 1000, 0));
        pending_q.push_back(mk(1, 0, 0, 0, 256001, 10, 10, 1000, 0));
        pending_q.push_back(mk(1, -5000, 0, -5000, -4000, 0, -4000, 1000, 0));
        pending_q.push_back(mk(0, 1000, 0, 0, 0, 0, 0, 1000, 0));
        pending_q.push_back(mk(0, 1001, 0, 0, 0, 0, 0, 1000, 0));
        wait_drained();
        apb_write(REG_ANGLE_MIN, 64'd65535);
        apb_write(REG_ANGLE_MAX, 64'd0);
        apb_write(REG_VIEW_DIR, 64'h7fff_8000_ffff);
        apb_write(REG_ORIGIN_X, 64'h7fffff);
        apb_write(REG_ORIGIN_Y, 64'h800000);
        apb_write(REG_ORIGIN_Z, 64'h7fffff);
        for (int i = 0; i < 8; i++)
            pending_q.push_back(rand_query());
        wait_drained();

        // random phases, each under a fresh setup
        for (int ph = 0; ph < 12; ph++)
        begin
            random_setup(ph % 4 == 3);
            for (int i = 0; i < 100; i++)
                pending_q.push_back(rand_query());
            if (ph == 5)
            begin
                // sender pauses until every expected beat has come
                while (pending_q.size() > 50) @(posedge clk);
                hold_send = 1;
                while (in_valid || vis_expected_q.size() > 0) @(posedge clk);
                hold_send = 0;
            end
            wait_drained();
        end
        if (errors == 0)
            $display("PASS view_area_visibility_test");
        else
            $display("FAIL view_area_visibility_test");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("FAIL view_area_visibility_test");
        $finish;
    end

endmodule
